// ===== rtl/core/tmrq_pkg.sv =====
// ----------------------------------------------------------------------------
// Token match request queue package
// Opcodes, status codes and beat layout shared by the queue RTL.
// ----------------------------------------------------------------------------
package tmrq_pkg;

  // Beat layout.
  localparam int OPCODE_BITS = 2;
  localparam int FIELD_BITS  = 8;   // rank and per-type counts on the ports
  localparam int FIELD_TYPES = 4;   // count fields carried on the ports
  localparam int STATUS_BITS = 2;
  localparam int OCC_BITS    = 5;
  localparam int TDATA_BITS  = 48;
  localparam int WIDE_BITS   = 16;  // scratch width for zero extension

  // Opcodes.
  localparam logic [OPCODE_BITS-1:0] OP_APPEND = 2'd0;
  localparam logic [OPCODE_BITS-1:0] OP_SERVE  = 2'd1;
  localparam logic [OPCODE_BITS-1:0] OP_DELETE = 2'd2;
  localparam logic [OPCODE_BITS-1:0] OP_NOP    = 2'd3;

  // Status codes.
  localparam logic [STATUS_BITS-1:0] STAT_OK   = 2'd0;
  localparam logic [STATUS_BITS-1:0] STAT_FULL = 2'd1;
  localparam logic [STATUS_BITS-1:0] STAT_NONE = 2'd2;

endpackage

// ===== rtl/core/token_match_request_queue.sv =====
// ----------------------------------------------------------------------------
// Token match request queue
// Ordered queue of requesters with append, serve-best-match and delete.
// ----------------------------------------------------------------------------
// Usage: one command beat enters on the s_* channel and exactly one result
// beat leaves on the m_* channel. Append adds a requester at the tail, delete
// removes the first entry with a matching rank, and serve scores every entry
// against an available-token vector and removes the earliest entry with the
// highest positive score. Removal moves the entries behind it up by one.
// The queue lives in one synchronous memory (one write and one read port,
// registered read data), so work is sequenced one command at a time:
//   append, no-op, or a serve/delete on an empty queue: the command goes
//   straight to the done state and its result beat is loaded into the output
//   register once that is free. Serve/delete on N entries: a scan with one
//   read per entry, then a score and a compare stage; a miss then goes to the
//   done state. Removing entry k adds compaction (read entry i+1, write it
//   back to i) for every entry behind it.
// s_tready is high whenever no command is in progress, even while a result
// waits on m_*; a stalled receiver only holds the finished result in the
// output register and the next command waits at its end. Reset clears the
// entry count and control state; memory contents are never read unwritten.
// ----------------------------------------------------------------------------
module token_match_request_queue #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TYPES       = 4,
  parameter int COUNT_BITS  = 8,
  parameter int RANK_BITS   = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // opcode[1:0], rank[9:2], count_0[17:10], count_1[25:18], count_2[33:26],
  // count_3[41:34], zero fill above.
  input  logic [tmrq_pkg::TDATA_BITS-1:0] s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // status[1:0], served_rank[9:2], need_0[17:10], need_1[25:18],
  // need_2[33:26], need_3[41:34], occupancy[46:42], zero fill above.
  output logic [tmrq_pkg::TDATA_BITS-1:0] m_tdata
);

  localparam int IDX_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS   = $clog2(QUEUE_DEPTH + 1);
  localparam int ENTRY_BITS = RANK_BITS + TYPES * COUNT_BITS;
  localparam int TOP_BITS   = COUNT_BITS + $clog2(TYPES + 1);
  localparam int SCORE_BITS = COUNT_BITS + $clog2(TYPES * (TYPES + 1) + 1);
  localparam int FB         = tmrq_pkg::FIELD_BITS;
  localparam int OB         = tmrq_pkg::OPCODE_BITS;
  localparam int SB         = tmrq_pkg::STATUS_BITS;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  // Queue storage: rank in the low bits, need of type t above it.
  logic [ENTRY_BITS-1:0] mem [QUEUE_DEPTH];
  logic [ENTRY_BITS-1:0] rdata;

  logic [1:0]            state;
  logic [CNT_BITS-1:0]   count;
  logic [OB-1:0]         op_q;
  logic [RANK_BITS-1:0]  key;
  logic [COUNT_BITS-1:0] avail [TYPES];
  logic [TOP_BITS-1:0]   top_q;

  // Scan pipeline: read issue, score stage, compare stage.
  logic [CNT_BITS-1:0]   scan_rd;
  logic                  p1_valid;
  logic [IDX_BITS-1:0]   p1_idx;
  logic                  p2_valid;
  logic [IDX_BITS-1:0]   p2_idx;
  logic [SCORE_BITS-1:0] p2_score;
  logic                  p2_hit;
  logic [ENTRY_BITS-1:0] p2_entry;
  logic [SCORE_BITS-1:0] best;
  logic [IDX_BITS-1:0]   best_idx;
  logic [ENTRY_BITS-1:0] best_entry;
  logic                  found;

  // Compaction.
  logic [CNT_BITS-1:0]   sh_rd;
  logic [CNT_BITS-1:0]   sh_prev;
  logic                  pend_valid;
  logic [IDX_BITS-1:0]   pend_addr;

  // Finished result waiting for the output register.
  logic [SB-1:0]         res_status;
  logic [ENTRY_BITS-1:0] res_entry;

  // Input decode.
  logic [tmrq_pkg::WIDE_BITS-1:0] in_ext [8];
  logic [COUNT_BITS-1:0]          in_vec [TYPES];
  logic [COUNT_BITS-1:0]          in_max;
  logic [tmrq_pkg::WIDE_BITS-1:0] in_rank_ext;
  logic [OB-1:0]                  in_op;
  logic                           accept;

  // Memory port controls.
  logic                  rd_en;
  logic [IDX_BITS-1:0]   rd_addr;
  logic                  wr_en;
  logic [IDX_BITS-1:0]   wr_addr;
  logic [ENTRY_BITS-1:0] wr_data;
  logic [ENTRY_BITS-1:0] app_entry;

  logic [SCORE_BITS-1:0] cur_score;
  logic                  cur_hit;
  logic                  scan_issue;
  logic                  shift_issue;
  logic                  out_load;

  // Output formatting.
  logic [tmrq_pkg::WIDE_BITS-1:0] out_need [8];
  logic [tmrq_pkg::WIDE_BITS-1:0] out_rank;
  logic [tmrq_pkg::WIDE_BITS-1:0] out_occ;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign in_op    = s_tdata[OB-1:0];

  always_comb begin
    in_ext[0] = tmrq_pkg::WIDE_BITS'(s_tdata[OB + FB +: FB]);
    in_ext[1] = tmrq_pkg::WIDE_BITS'(s_tdata[OB + 2 * FB +: FB]);
    in_ext[2] = tmrq_pkg::WIDE_BITS'(s_tdata[OB + 3 * FB +: FB]);
    in_ext[3] = tmrq_pkg::WIDE_BITS'(s_tdata[OB + 4 * FB +: FB]);
    for (int t = tmrq_pkg::FIELD_TYPES; t < 8; t++) begin
      in_ext[t] = '0;
    end
    in_rank_ext = tmrq_pkg::WIDE_BITS'(s_tdata[OB +: FB]);
    in_max = '0;
    app_entry = '0;
    app_entry[RANK_BITS-1:0] = in_rank_ext[RANK_BITS-1:0];
    for (int t = 0; t < TYPES; t++) begin
      in_vec[t] = in_ext[t][COUNT_BITS-1:0];
      if (in_vec[t] > in_max) begin
        in_max = in_vec[t];
      end
      app_entry[RANK_BITS + t * COUNT_BITS +: COUNT_BITS] = in_vec[t];
    end
  end

  // Score of the entry whose read data is arriving this cycle.
  always_comb begin
    logic [COUNT_BITS-1:0] nd;
    logic [COUNT_BITS-1:0] mn;
    cur_score = '0;
    for (int t = 0; t < TYPES; t++) begin
      nd = rdata[RANK_BITS + t * COUNT_BITS +: COUNT_BITS];
      mn = (avail[t] <= nd) ? avail[t] : nd;
      if (avail[t] != '0 && nd != '0) begin
        cur_score = cur_score + SCORE_BITS'(top_q) + SCORE_BITS'(mn);
      end
    end
    cur_hit = (rdata[RANK_BITS-1:0] == key);
  end

  assign scan_issue  = (state == S_SCAN) && (scan_rd < count);
  assign shift_issue = (state == S_SHIFT) && (sh_rd < count);
  assign sh_prev     = sh_rd - CNT_BITS'(1);

  always_comb begin
    rd_en   = scan_issue || shift_issue;
    rd_addr = (state == S_SCAN) ? scan_rd[IDX_BITS-1:0] : sh_rd[IDX_BITS-1:0];
    if (state == S_SHIFT) begin
      wr_en   = pend_valid;
      wr_addr = pend_addr;
      wr_data = rdata;
    end else begin
      wr_en   = accept && (in_op == tmrq_pkg::OP_APPEND) &&
                (count < CNT_BITS'(QUEUE_DEPTH));
      wr_addr = count[IDX_BITS-1:0];
      wr_data = app_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  assign out_load = (state == S_DONE) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      p1_valid   <= 1'b0;
      p2_valid   <= 1'b0;
      pend_valid <= 1'b0;
      found      <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op_q     <= in_op;
            key      <= in_rank_ext[RANK_BITS-1:0];
            avail    <= in_vec;
            top_q    <= TOP_BITS'(in_max) * TOP_BITS'(TYPES);
            best     <= '0;
            found    <= 1'b0;
            scan_rd  <= '0;
            p1_valid <= 1'b0;
            p2_valid <= 1'b0;
            res_entry  <= '0;
            res_status <= tmrq_pkg::STAT_OK;
            case (in_op)
              tmrq_pkg::OP_APPEND: begin
                if (count < CNT_BITS'(QUEUE_DEPTH)) begin
                  count <= count + CNT_BITS'(1);
                end else begin
                  res_status <= tmrq_pkg::STAT_FULL;
                end
                state <= S_DONE;
              end
              tmrq_pkg::OP_SERVE, tmrq_pkg::OP_DELETE: begin
                if (count == '0) begin
                  res_status <= tmrq_pkg::STAT_NONE;
                  state      <= S_DONE;
                end else begin
                  state <= S_SCAN;
                end
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (scan_issue) begin
            scan_rd <= scan_rd + CNT_BITS'(1);
          end
          p1_valid <= scan_issue;
          p1_idx   <= scan_rd[IDX_BITS-1:0];
          p2_valid <= p1_valid;
          p2_idx   <= p1_idx;
          p2_score <= cur_score;
          p2_hit   <= cur_hit;
          p2_entry <= rdata;
          if (p2_valid) begin
            // Serve keeps the earliest strictly best score; delete keeps
            // the first matching rank.
            if ((op_q == tmrq_pkg::OP_SERVE && p2_score > best) ||
                (op_q == tmrq_pkg::OP_DELETE && p2_hit && !found)) begin
              best       <= p2_score;
              best_idx   <= p2_idx;
              best_entry <= p2_entry;
              found      <= 1'b1;
            end
          end
          if (!scan_issue && !p1_valid && !p2_valid) begin
            if (found) begin
              sh_rd      <= CNT_BITS'(best_idx) + CNT_BITS'(1);
              pend_valid <= 1'b0;
              state      <= S_SHIFT;
            end else begin
              res_status <= tmrq_pkg::STAT_NONE;
              state      <= S_DONE;
            end
          end
        end
        S_SHIFT: begin
          // Read the next entry while writing back the previously read entry one slot lower.
          if (shift_issue) begin
            sh_rd <= sh_rd + CNT_BITS'(1);
          end
          pend_valid <= shift_issue;
          pend_addr  <= sh_prev[IDX_BITS-1:0];
          if (!shift_issue && !pend_valid) begin
            count      <= count - CNT_BITS'(1);
            res_status <= tmrq_pkg::STAT_OK;
            res_entry  <= best_entry;
            state      <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if (out_load) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {{(tmrq_pkg::TDATA_BITS - SB - 5 * FB - tmrq_pkg::OCC_BITS){1'b0}},
                     out_occ[tmrq_pkg::OCC_BITS-1:0],
                     out_need[3][FB-1:0], out_need[2][FB-1:0],
                     out_need[1][FB-1:0], out_need[0][FB-1:0],
                     out_rank[FB-1:0], res_status};
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_comb begin
    for (int t = 0; t < 8; t++) begin
      out_need[t] = '0;
    end
    for (int t = 0; t < TYPES; t++) begin
      out_need[t] = tmrq_pkg::WIDE_BITS'(res_entry[RANK_BITS + t * COUNT_BITS +: COUNT_BITS]);
    end
    out_rank = tmrq_pkg::WIDE_BITS'(res_entry[RANK_BITS-1:0]);
    out_occ  = tmrq_pkg::WIDE_BITS'(count);
  end

  // The entry count never passes the queue depth.
  assert property (@(posedge clk) disable iff (rst)
    count <= CNT_BITS'(QUEUE_DEPTH))
    else $error("queue count exceeds depth");

  // Compaction only runs after a hit and writes below the last valid entry.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT) |-> (found && CNT_BITS'(best_idx) < count))
    else $error("compaction without a valid removal target");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT && pend_valid) |-> (CNT_BITS'(pend_addr) + CNT_BITS'(1) < count))
    else $error("compaction write outside the queue");

  // The scan read pointer stays within the queue.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (scan_rd <= count))
    else $error("scan pointer past the queue tail");

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// Token match request queue testbench
// Streams append, serve, delete and no-op commands into the queue, predicts
// every result beat from a behavioral copy of the queue kept in the bench,
// and checks the result stream field by field under random backpressure.
// ----------------------------------------------------------------------------
module tb;

  localparam int FIELD_BITS   = tmrq_pkg::FIELD_BITS;
  localparam int FIELD_TYPES  = tmrq_pkg::FIELD_TYPES;
  localparam int OPCODE_BITS  = tmrq_pkg::OPCODE_BITS;
  localparam int STATUS_BITS  = tmrq_pkg::STATUS_BITS;
  localparam int OCC_BITS     = tmrq_pkg::OCC_BITS;
  localparam int TDATA_BITS   = tmrq_pkg::TDATA_BITS;

  localparam int DEPTH        = 16;
  localparam int RANDOM_ITEMS = 1530;
  localparam int PHASE_ITEMS  = 40;      // items per fill or drain phase
  localparam int MAX_GAP      = 13;
  localparam int HOLD_AT      = 200;     // result beats before the long hold-off
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 60;      // covers one full scan plus compaction
  localparam int TIMEOUT      = 4000000;
  localparam int NUM_FIELDS   = 7;

  // One command as it sits in the low bits of s_tdata: opcode lowest, then
  // rank, then the four counts with count_0 in the lowest byte of counts.
  typedef struct packed {
    logic [4*FIELD_BITS-1:0]  counts;
    logic [FIELD_BITS-1:0]    rank;
    logic [OPCODE_BITS-1:0]   opcode;
  } command_t;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [TDATA_BITS-1:0] s_tdata  = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [TDATA_BITS-1:0] m_tdata;

  always #5 clk = ~clk;

  token_match_request_queue #(
    .QUEUE_DEPTH (DEPTH),
    .TYPES       (FIELD_TYPES),
    .COUNT_BITS  (FIELD_BITS),
    .RANK_BITS   (FIELD_BITS)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // opcode, rank, count_0..count_3, zero fill
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)    // status, served_rank, need_0..need_3, occupancy
  );

  // Commands waiting to be offered, and result beats the queue still owes us.
  command_t              pending [$];
  logic [TDATA_BITS-1:0] owed_results [$];
  command_t              offered;

  // Shadow copy of the queue contents, in queue order.
  logic [FIELD_BITS-1:0]   shadow_rank [DEPTH];
  logic [4*FIELD_BITS-1:0] shadow_need [DEPTH];
  int                      shadow_len = 0;

  // Bookkeeping for the summary.
  int status_seen [3] = '{0, 0, 0};
  int peak_len        = 0;
  int errors          = 0;
  int beats_out       = 0;

  // Handshake flags raised at the rising edge, consumed at the falling edge.
  bit cmd_taken = 0;
  bit rsp_taken = 0;

  int tx_gap    = 0;
  int rx_gap    = 0;
  bit tx_burst  = 0;
  bit rx_burst  = 0;
  int hold_left = 0;
  bit hold_done = 0;

  function automatic command_t cmd(logic [OPCODE_BITS-1:0] op, logic [FIELD_BITS-1:0] rk,
                                   logic [4*FIELD_BITS-1:0] counts);
    cmd = '{counts: counts, rank: rk, opcode: op};
  endfunction

  // Result beat layout, lowest field first.
  function automatic int field_lo(int f);
    field_lo = (f == 0) ? 0 : STATUS_BITS + FIELD_BITS * (f - 1);
  endfunction

  function automatic int field_w(int f);
    field_w = (f == 0) ? STATUS_BITS : ((f == NUM_FIELDS - 1) ? OCC_BITS : FIELD_BITS);
  endfunction

  function automatic string field_name(int f);
    case (f)
      0:       field_name = "status";
      1:       field_name = "served_rank";
      2:       field_name = "need_0";
      3:       field_name = "need_1";
      4:       field_name = "need_2";
      5:       field_name = "need_3";
      default: field_name = "occupancy";
    endcase
  endfunction

  function automatic int field_of(logic [TDATA_BITS-1:0] beat, int f);
    logic [TDATA_BITS-1:0] mask;
    mask     = (TDATA_BITS'(1) << field_w(f)) - TDATA_BITS'(1);
    field_of = int'((beat >> field_lo(f)) & mask);
  endfunction

  // Applies one command to the shadow queue and returns the result beat the
  // block must produce for it. Serve picks the earliest entry with the
  // highest score, and only if that score is above zero.
  function automatic logic [TDATA_BITS-1:0] apply_command(command_t c);
    logic [STATUS_BITS-1:0]  st;
    logic [FIELD_BITS-1:0]   out_rank;
    logic [4*FIELD_BITS-1:0] out_need;
    int                      hit;
    longint                  top;
    longint                  best;
    longint                  score;
    longint                  avail;
    longint                  need;
    st       = tmrq_pkg::STAT_OK;
    out_rank = '0;
    out_need = '0;
    hit      = -1;
    case (c.opcode)
      tmrq_pkg::OP_APPEND: begin
        if (shadow_len >= DEPTH) begin
          st = tmrq_pkg::STAT_FULL;
        end else begin
          shadow_rank[shadow_len] = c.rank;
          shadow_need[shadow_len] = c.counts;
          shadow_len++;
        end
      end
      tmrq_pkg::OP_SERVE: begin
        top = 0;
        for (int t = 0; t < FIELD_TYPES; t++) begin
          avail = longint'(c.counts[FIELD_BITS*t +: FIELD_BITS]);
          if (avail > top) top = avail;
        end
        top  = top * FIELD_TYPES;
        best = 0;
        for (int i = 0; i < shadow_len; i++) begin
          score = 0;
          for (int t = 0; t < FIELD_TYPES; t++) begin
            avail = longint'(c.counts[FIELD_BITS*t +: FIELD_BITS]);
            need  = longint'(shadow_need[i][FIELD_BITS*t +: FIELD_BITS]);
            if (avail != 0 && need != 0) score += top + ((avail <= need) ? avail : need);
          end
          if (score > best) begin
            best = score;
            hit  = i;
          end
        end
      end
      tmrq_pkg::OP_DELETE: begin
        for (int i = 0; i < shadow_len; i++) begin
          if (hit < 0 && shadow_rank[i] == c.rank) hit = i;
        end
      end
      default: ;
    endcase

    if (hit >= 0) begin
      // Removal keeps order: everything behind the hit moves up one slot.
      out_rank = shadow_rank[hit];
      out_need = shadow_need[hit];
      for (int i = hit; i + 1 < shadow_len; i++) begin
        shadow_rank[i] = shadow_rank[i+1];
        shadow_need[i] = shadow_need[i+1];
      end
      shadow_len--;
    end else if (c.opcode == tmrq_pkg::OP_SERVE || c.opcode == tmrq_pkg::OP_DELETE) begin
      st = tmrq_pkg::STAT_NONE;
    end

    status_seen[st]++;
    if (shadow_len > peak_len) peak_len = shadow_len;
    return {1'b0, OCC_BITS'(shadow_len), out_need, out_rank, st};
  endfunction

  // Rising edge: predict on every accepted command, then check every accepted
  // result beat against the oldest prediction. Prediction runs first so that
  // ordering inside this block is fixed.
  always @(posedge clk) begin
    logic [TDATA_BITS-1:0] want;
    int                    exp_f;
    int                    got_f;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        owed_results.push_back(apply_command(offered));
        cmd_taken = 1;
      end
      if (m_tvalid && m_tready) begin
        rsp_taken = 1;
        beats_out <= beats_out + 1;
        if (owed_results.size() == 0) begin
          $display("%0t: result beat with nothing outstanding: expected none, got %h",
                   $time, m_tdata);
          errors++;
        end else begin
          want = owed_results.pop_front();
          for (int f = 0; f < NUM_FIELDS; f++) begin
            exp_f = field_of(want, f);
            got_f = field_of(m_tdata, f);
            if (exp_f != got_f) begin
              $display("%0t: %s mismatch: expected %0d, got %0d",
                       $time, field_name(f), exp_f, got_f);
              errors++;
            end
          end
        end
      end
    end
  end

  // Command driver. After a beat is taken, tvalid drops for the drawn gap; a
  // gap of zero keeps tvalid high straight into the next command. Burst mode
  // flips now and then so that long stretches run with no gaps at all.
  always @(negedge clk) begin
    logic next_valid;
    if (!rst) begin
      next_valid = s_tvalid;
      if (cmd_taken) begin
        cmd_taken  = 0;
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (pending.size() != 0) begin
          offered    = pending.pop_front();
          s_tdata   <= TDATA_BITS'(offered);
          next_valid = 1'b1;
          tx_gap     = tx_burst ? 0 : int'($urandom_range(0, MAX_GAP));
          if ($urandom_range(0, 49) == 0) tx_burst = !tx_burst;
        end
      end
      s_tvalid <= next_valid;
    end
  end

  // Result receiver: tready goes low for a drawn number of cycles after each
  // beat, and stays low for the whole long hold-off.
  always @(negedge clk) begin
    if (!rst) begin
      if (rsp_taken) begin
        rsp_taken = 0;
        rx_gap    = rx_burst ? 0 : int'($urandom_range(0, MAX_GAP));
        if ($urandom_range(0, 49) == 0) rx_burst = !rx_burst;
      end else if (rx_gap > 0) begin
        rx_gap--;
      end
      m_tready <= (rx_gap == 0) && (hold_left == 0);
    end
  end

  // Long hold-off, counted here: once enough results have gone by, the
  // receiver stops for a long stretch while the driver keeps offering, so the
  // output register fills and the queue has to stall its command input.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && beats_out >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1;
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    logic [4*FIELD_BITS-1:0] vec;
    logic [FIELD_BITS-1:0]   rk;
    logic [OPCODE_BITS-1:0]  op;
    int                      pick;
    int                      r;
    bit                      filling;

    // Directed part. Serve and delete on an empty queue both miss.
    pending.push_back(cmd(tmrq_pkg::OP_SERVE,  8'd0,   32'hFFFF_FFFF));
    pending.push_back(cmd(tmrq_pkg::OP_DELETE, 8'd0,   32'h0000_0000));
    // A zero need never scores, an all-ones need always can, and rank 7 is
    // appended twice to check that delete takes the earlier copy.
    pending.push_back(cmd(tmrq_pkg::OP_APPEND, 8'd0,   32'h0000_0000));
    pending.push_back(cmd(tmrq_pkg::OP_APPEND, 8'd255, 32'hFFFF_FFFF));
    pending.push_back(cmd(tmrq_pkg::OP_APPEND, 8'd7,   32'h0003_0001));
    pending.push_back(cmd(tmrq_pkg::OP_APPEND, 8'd7,   32'h0000_0500));
    // Fill to the top with identical needs, then one append too many.
    for (int i = 0; i < DEPTH - 4; i++)
      pending.push_back(cmd(tmrq_pkg::OP_APPEND, FIELD_BITS'(100 + i), 32'h0808_0808));
    pending.push_back(cmd(tmrq_pkg::OP_APPEND, 8'd42,  32'h0101_0101));
    // Rank 255 ties with every filler entry; the earliest of the tie wins.
    pending.push_back(cmd(tmrq_pkg::OP_SERVE,  8'd0,   32'h0808_0808));
    pending.push_back(cmd(tmrq_pkg::OP_DELETE, 8'd7,   32'h0000_0000));
    pending.push_back(cmd(tmrq_pkg::OP_DELETE, 8'd99,  32'h0000_0000));
    // No token available scores zero everywhere, so nothing is served.
    pending.push_back(cmd(tmrq_pkg::OP_SERVE,  8'd0,   32'h0000_0000));
    // A no-op with every input bit set still reports a zero rank and zero needs.
    pending.push_back(cmd(tmrq_pkg::OP_NOP,    8'd255, 32'hFFFF_FFFF));

    // Random part, in fill and drain phases picked at random so the queue swings
    // between empty and full. A small rank pool lets deletes find entries.
    filling = 1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % PHASE_ITEMS == 0) filling = 1'($urandom_range(0, 1));
      for (int t = 0; t < FIELD_TYPES; t++) begin
        r = int'($urandom_range(0, 9));
        if (r < 3)       vec[FIELD_BITS*t +: FIELD_BITS] = '0;
        else if (r == 3) vec[FIELD_BITS*t +: FIELD_BITS] = '1;
        else             vec[FIELD_BITS*t +: FIELD_BITS] = FIELD_BITS'($urandom_range(1, 255));
      end
      rk   = ($urandom_range(0, 1) != 0) ? FIELD_BITS'($urandom_range(0, 15))
                                         : FIELD_BITS'($urandom_range(0, 255));
      pick = int'($urandom_range(0, 99));
      if (pick < 5)                          op = tmrq_pkg::OP_NOP;
      else if (pick < (filling ? 70 : 25))   op = tmrq_pkg::OP_APPEND;
      else if (pick < (filling ? 85 : 65))   op = tmrq_pkg::OP_SERVE;
      else                                   op = tmrq_pkg::OP_DELETE;
      pending.push_back(cmd(op, rk, vec));
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (pending.size() != 0 || s_tvalid || owed_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d commands: %0d completed, %0d appends dropped on a full queue,",
             status_seen[tmrq_pkg::STAT_OK] + status_seen[tmrq_pkg::STAT_FULL] +
             status_seen[tmrq_pkg::STAT_NONE],
             status_seen[tmrq_pkg::STAT_OK], status_seen[tmrq_pkg::STAT_FULL]);
    $display("%0d serves or deletes with no match; queue peaked at %0d entries.",
             status_seen[tmrq_pkg::STAT_NONE], peak_len);
    if (errors == 0) begin
      $display("PASS token_match_request_queue");
    end else begin
      $display("FAIL token_match_request_queue");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(TIMEOUT);
    $display("FAIL token_match_request_queue");
    $finish;
  end

endmodule
